### src/sfs_pkg.sv
// ----------------------------------------------------------------------------
// sfs_pkg: shared types and constants for the sonde frame sync CRC check
// Frame geometry, sync byte, the queue item record and the CRC-16 step.
// ----------------------------------------------------------------------------
package sfs_pkg;

	localparam int FRAME_LEN = 101;
	localparam int CHECK_POS = 99;
	localparam int POS_W     = 8;

	localparam logic [7:0]  SYNC_BYTE = 8'hAA;
	localparam logic [15:0] CRC_INIT  = 16'hFFFF;
	localparam logic [15:0] CRC_POLY  = 16'hA001;
	localparam logic [15:0] CRC_LSB   = 16'h0001;

	localparam int QUEUE_DEPTH = 2;
	localparam int QPTR_W      = 1;
	localparam int QCNT_W      = 2;

	// one classified byte on its way from front to back
	typedef struct packed {
		logic [7:0] data;
		logic       in_frame;
		logic [6:0] idx;
		logic       open;
		logic       crc_en;
		logic       chk_hi;
		logic       chk_lo;
		logic       last;
	} item_t;

	// reflected CRC-16 over one byte, LSB first
	function automatic logic [15:0] crc_byte(input logic [15:0] crc, input logic [7:0] b);
		logic [15:0] c;
		c = crc ^ {8'h00, b};
		for (int i = 0; i < 8; i++) begin
			if ((c & CRC_LSB) != 16'h0000) begin
				c = (c >> 1) ^ CRC_POLY;
			end else begin
				c = c >> 1;
			end
		end
		return c;
	endfunction

	// CRC state once the three sync bytes are in
	localparam logic [15:0] CRC_SYNC3 =
		crc_byte(crc_byte(crc_byte(CRC_INIT, SYNC_BYTE), SYNC_BYTE), SYNC_BYTE);

endpackage

### src/sfs_front.sv
// ----------------------------------------------------------------------------
// sfs_front: byte classifier
// Hunts for the sync run, tracks the frame position and tags each item.
// ----------------------------------------------------------------------------
module sfs_front import sfs_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic [7:0] rx_byte,
	input  logic       rx_valid,
	output logic       rx_ready,
	input  logic       q_full,
	output logic       push,
	output item_t      push_item
);

	logic             locked_q;
	logic [1:0]       sync_run_q;
	logic [POS_W-1:0] pos_q;

	logic             is_sync;
	logic [POS_W:0]   pos_ext;
	item_t            it;

	assign rx_ready = !q_full;
	assign push     = rx_valid && rx_ready;
	assign is_sync  = (rx_byte == SYNC_BYTE);
	assign pos_ext  = {1'b0, pos_q};

	always_comb begin
		it          = '0;
		it.data     = rx_byte;
		if (!locked_q) begin
			it.idx  = is_sync ? {5'b0, sync_run_q} : 7'd0;
			it.open = is_sync && (sync_run_q == 2'd2);
		end else begin
			it.in_frame = 1'b1;
			it.idx      = pos_q[6:0];
			it.crc_en   = (pos_ext + (POS_W+1)'(2)) < (POS_W+1)'(FRAME_LEN);
			it.chk_hi   = pos_ext == (POS_W+1)'(CHECK_POS);
			it.chk_lo   = pos_ext == (POS_W+1)'(CHECK_POS + 1);
			it.last     = (pos_ext + (POS_W+1)'(1)) >= (POS_W+1)'(FRAME_LEN);
		end
		push_item = it;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			locked_q   <= 1'b0;
			sync_run_q <= 2'd0;
			pos_q      <= '0;
		end else if (push) begin
			if (!locked_q) begin
				if (it.open) begin
					locked_q   <= 1'b1;
					sync_run_q <= 2'd0;
					pos_q      <= POS_W'(3);
				end else if (is_sync) begin
					sync_run_q <= sync_run_q + 2'd1;
				end else begin
					sync_run_q <= 2'd0;
				end
			end else if (it.last) begin
				// close frame, resume hunting
				locked_q   <= 1'b0;
				sync_run_q <= 2'd0;
				pos_q      <= '0;
			end else begin
				pos_q <= pos_q + POS_W'(1);
			end
		end
	end

endmodule

### src/sfs_queue.sv
// ----------------------------------------------------------------------------
// sfs_queue: small item queue
// Decouples the classifier from the CRC back end.
// ----------------------------------------------------------------------------
module sfs_queue import sfs_pkg::*; (
	input  logic  clk,
	input  logic  arst_n,
	input  logic  push,
	input  item_t push_item,
	output logic  full,
	output logic  pop_valid,
	input  logic  pop,
	output item_t pop_item
);

	item_t             mem [QUEUE_DEPTH];
	logic [QPTR_W-1:0] wr_ptr_q;
	logic [QPTR_W-1:0] rd_ptr_q;
	logic [QCNT_W-1:0] count_q;

	logic do_pop;

	assign full      = (count_q == QCNT_W'(QUEUE_DEPTH));
	assign pop_valid = (count_q != '0);
	assign do_pop    = pop && pop_valid;
	assign pop_item  = mem[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem[wr_ptr_q] <= push_item;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + QPTR_W'(1);
			end
			if (do_pop) begin
				rd_ptr_q <= rd_ptr_q + QPTR_W'(1);
			end
			if (push && !do_pop) begin
				count_q <= count_q + QCNT_W'(1);
			end else if (!push && do_pop) begin
				count_q <= count_q - QCNT_W'(1);
			end
		end
	end

endmodule

### src/sfs_back.sv
// ----------------------------------------------------------------------------
// sfs_back: CRC and check word back end
// Runs the CRC, latches the check word and registers each result item.
// ----------------------------------------------------------------------------
module sfs_back import sfs_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       skip_crc,
	input  logic       pop_valid,
	output logic       pop,
	input  item_t      pop_item,
	output logic       res_valid,
	input  logic       res_ready,
	output logic       in_frame,
	output logic [6:0] byte_index,
	output logic [7:0] byte_out,
	output logic       frame_end,
	output logic       frame_good
);

	logic [15:0] crc_q;
	logic [15:0] chk_q;
	logic        valid_q;
	logic        in_frame_q;
	logic [6:0]  idx_q;
	logic [7:0]  byte_q;
	logic        end_q;
	logic        good_q;

	logic        take;
	logic [15:0] chk_next;
	logic [15:0] crc_next;

	assign pop  = !valid_q || res_ready;
	assign take = pop && pop_valid;

	always_comb begin
		chk_next = chk_q;
		crc_next = crc_q;
		if (pop_item.open) begin
			chk_next = 16'h0000;
			crc_next = CRC_SYNC3;
		end else if (pop_item.in_frame) begin
			if (pop_item.chk_hi) begin
				chk_next[15:8] = pop_item.data;
			end
			if (pop_item.chk_lo) begin
				chk_next[7:0] = pop_item.data;
			end
			if (pop_item.crc_en) begin
				crc_next = crc_byte(crc_q, pop_item.data);
			end
			if (pop_item.last) begin
				crc_next = CRC_INIT;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			crc_q   <= CRC_INIT;
			chk_q   <= 16'h0000;
			valid_q <= 1'b0;
		end else begin
			if (take) begin
				crc_q   <= crc_next;
				chk_q   <= chk_next;
				valid_q <= 1'b1;
			end else if (res_ready) begin
				valid_q <= 1'b0;
			end
		end
	end

	// hold the result until taken
	always_ff @(posedge clk) begin
		if (take) begin
			in_frame_q <= pop_item.in_frame;
			idx_q      <= pop_item.idx;
			byte_q     <= pop_item.data;
			end_q      <= pop_item.last;
			good_q     <= pop_item.last && (skip_crc || (crc_q == chk_next));
		end
	end

	assign res_valid  = valid_q;
	assign in_frame   = in_frame_q;
	assign byte_index = idx_q;
	assign byte_out   = byte_q;
	assign frame_end  = end_q;
	assign frame_good = good_q;

endmodule

### src/sonde_frame_sync_crc_check.sv
// Path: an accepted byte is written into the queue, then taken into the back end's
// output register, which shows it on the result ports. Throughput: one byte per
// cycle while res_ready is high, set by the single-byte CRC step in the back end.
// Reset: hunting, empty queue, no result pending, CRC at all ones, skip_crc 0.
// ----------------------------------------------------------------------------
// sonde_frame_sync_crc_check: frame sync with CRC-16 check
// Finds three 0xAA sync bytes, echoes frame bytes and checks the frame CRC.
// ----------------------------------------------------------------------------
module sonde_frame_sync_crc_check import sfs_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       cfg_we,
	input  logic       cfg_data,
	input  logic [7:0] rx_byte,
	input  logic       rx_valid,
	output logic       rx_ready,
	output logic       res_valid,
	input  logic       res_ready,
	output logic       in_frame,
	output logic [6:0] byte_index,
	output logic [7:0] byte_out,
	output logic       frame_end,
	output logic       frame_good
);

	logic  skip_crc_q;
	logic  q_full;
	logic  push;
	item_t push_item;
	logic  pop_valid;
	logic  pop;
	item_t pop_item;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			skip_crc_q <= 1'b0;
		end else if (cfg_we) begin
			skip_crc_q <= cfg_data;
		end
	end

	sfs_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.rx_byte   (rx_byte),
		.rx_valid  (rx_valid),
		.rx_ready  (rx_ready),
		.q_full    (q_full),
		.push      (push),
		.push_item (push_item)
	);

	sfs_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_item (push_item),
		.full      (q_full),
		.pop_valid (pop_valid),
		.pop       (pop),
		.pop_item  (pop_item)
	);

	sfs_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.skip_crc   (skip_crc_q),
		.pop_valid  (pop_valid),
		.pop        (pop),
		.pop_item   (pop_item),
		.res_valid  (res_valid),
		.res_ready  (res_ready),
		.in_frame   (in_frame),
		.byte_index (byte_index),
		.byte_out   (byte_out),
		.frame_end  (frame_end),
		.frame_good (frame_good)
	);

endmodule
